>>> hdl/assert_macros.svh
// Assertion macros shared by the rule engine RTL.
// Define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> hdl/srae_pkg.sv
// Package for the sensor rule action engine: payload structs, op codes,
// sequencer states and constants. No dependencies.
package srae_pkg;
    localparam int RULE_COUNT_DEF = 16;
    localparam int FLAG_COUNT_DEF = 5;
    localparam logic [15:0] RANGE_LIMIT = 16'd8190;
    localparam logic [15:0] RANGE_CLEAN = 16'd9999;

    typedef enum logic [2:0] {
        OP_TICK = 3'd0, OP_COND1 = 3'd1, OP_COND2 = 3'd2, OP_THEN = 3'd3, OP_ELSE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        REL_LT = 2'd0, REL_GT = 2'd1, REL_EQ = 2'd2, REL_NONE = 2'd3
    } t_rel;

    localparam logic [1:0] LINK_AND = 2'd1;
    localparam logic [1:0] LINK_OR  = 2'd2;
    localparam logic [3:0] SRC_DIST = 4'd1;
    localparam logic [3:0] SRC_LINE = 4'd2;
    localparam logic [3:0] SRC_FLAG = 4'd3;
    localparam logic [3:0] TGT_LEFT = 4'd1;
    localparam logic [3:0] TGT_RIGHT = 4'd2;
    localparam logic [3:0] TGT_BOTH = 4'd3;
    localparam logic [3:0] TGT_FLAG = 4'd4;

    typedef enum logic [1:0] {
        ST_IDLE, ST_COND1, ST_COND2, ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]         op;
        logic [15:0]        range_mm;
        logic               range_timeout;
        logic               line_sensor;
        logic [47:0]        now_ms;
        logic [3:0]         rule_index;
        logic [3:0]         kind;
        logic [1:0]         relation;
        logic signed [15:0] value;
        logic [15:0]        extra;
    } t_in;

    typedef struct packed {
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic               moving;
        logic               held;
    } t_out;

    // One comparison request to the shared compare unit.
    typedef struct packed {
        logic [3:0]         src;
        logic [1:0]         rel;
        logic signed [15:0] thr;
    } t_cmp_req;
endpackage

>>> hdl/srae_cmp.sv
// Shared comparison unit: picks a source and compares it with a threshold.
// Depends on srae_pkg.
module srae_cmp #(
    parameter int FLAG_COUNT = srae_pkg::FLAG_COUNT_DEF
) (
    input  srae_pkg::t_cmp_req         i_req,
    input  logic signed [15:0]         i_dist,
    input  logic                       i_line,
    input  logic [FLAG_COUNT*16-1:0]   i_flags,
    output logic                       o_true
);
    import srae_pkg::*;
    logic signed [15:0] v;
    logic               ok;
    logic [3:0]         fidx;
    always_comb begin
        v = '0;
        ok = 1'b1;
        fidx = i_req.src - SRC_FLAG;
        if (i_req.src == SRC_DIST) begin
            v = i_dist;
        end else if (i_req.src == SRC_LINE) begin
            v = {15'd0, i_line};
        end else if (i_req.src >= SRC_FLAG && {28'd0, fidx} < FLAG_COUNT) begin
            v = i_flags[fidx*16 +: 16];
        end else begin
            ok = 1'b0;
        end
        case (t_rel'(i_req.rel))
            REL_LT:  o_true = ok && (v < i_req.thr);
            REL_GT:  o_true = ok && (v > i_req.thr);
            REL_EQ:  o_true = ok && (v == i_req.thr);
            default: o_true = 1'b0;
        endcase
    end
endmodule

>>> hdl/sensor_rule_action_engine.sv
// Top level of the sensor rule action engine: rule tables, flags, hold timer
// and the rule-walk sequencer. Depends on srae_pkg, srae_cmp, assert_macros.svh.
`include "assert_macros.svh"
// A write transaction (op 1 to 4) gives no result. A tick transaction walks
// the rule table with one shared compare unit: each active rule uses its
// first comparison, and the second one too when its link is AND or OR; a
// tick inside a running hold skips the walk and replays the locked speeds.
// busy is high from acceptance until the result strobe. o_valid is high for
// exactly one cycle with the result; the receiver cannot stall, so take it
// then. Unknown ops are dropped without a result.
module sensor_rule_action_engine #(
    parameter int RULE_COUNT = srae_pkg::RULE_COUNT_DEF,
    parameter int FLAG_COUNT = srae_pkg::FLAG_COUNT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  srae_pkg::t_in   i_item,
    output logic            o_valid,
    output srae_pkg::t_out  o_result
);
    import srae_pkg::*;
    localparam int RW = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
    localparam int CW = $clog2(RULE_COUNT + 1);

    // Rule tables in flip-flops; reset clears them (writes reach at most 16 entries, as rule_index is 4 bits).
    logic                r_active [RULE_COUNT];
    logic [1:0]          r_link   [RULE_COUNT];
    t_cmp_req            r_c1     [RULE_COUNT];
    t_cmp_req            r_c2     [RULE_COUNT];
    logic [3:0]          r_tkind  [RULE_COUNT];
    logic signed [15:0]  r_tval   [RULE_COUNT];
    logic [15:0]         r_dur    [RULE_COUNT];
    logic [3:0]          r_ekind  [RULE_COUNT];
    logic signed [15:0]  r_eval   [RULE_COUNT];
    logic [FLAG_COUNT*16-1:0] r_flags;

    logic [47:0]         r_hold_end;
    logic signed [15:0]  r_held_l, r_held_r;
    logic                r_hold_run;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_t1, n_t1;
    logic signed [15:0]  r_dist, r_left, r_right, n_left, n_right;
    logic                r_line;
    logic [47:0]         r_now;
    logic [15:0]         r_pend, n_pend;
    logic                r_held, n_held;
    logic                r_valid;
    logic                r_busy;

    logic [RW-1:0]       ri;
    logic [RW-1:0]       wr_idx;
    t_cmp_req            cmp_req;
    logic                cmp_true;
    logic                rule_t;
    logic                rule_done;
    logic [3:0]          act_k;
    logic signed [15:0]  act_v;
    logic                flag_we;
    logic [3:0]          flag_sel;

    assign ri = r_idx[RW-1:0];
    assign wr_idx = RW'(i_item.rule_index);

    srae_cmp #(.FLAG_COUNT(FLAG_COUNT)) u_cmp (
        .i_req(cmp_req), .i_dist(r_dist), .i_line(r_line),
        .i_flags(r_flags), .o_true(cmp_true)
    );

    logic accept;
    logic hold_hit;
    assign accept = start && !r_busy;
    assign busy = r_busy;
    // A tick inside a running hold replays the locked speeds.
    assign hold_hit = r_hold_run && (i_item.now_ms < r_hold_end);

    // Sequencer: one comparison per cycle through the shared unit.
    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_t1 = r_t1;
        n_left = r_left;
        n_right = r_right;
        n_pend = r_pend;
        n_held = r_held;
        cmp_req = r_c1[ri];
        rule_t = 1'b0;
        rule_done = 1'b0;
        act_k = '0;
        act_v = '0;
        flag_we = 1'b0;
        flag_sel = '0;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
            end
            ST_COND1: begin
                if (r_idx == CW'(RULE_COUNT)) begin
                    n_state = ST_DONE;
                end else if (!r_active[ri]) begin
                    n_idx = r_idx + 1'b1;
                end else if (r_link[ri] == LINK_AND || r_link[ri] == LINK_OR) begin
                    n_t1 = cmp_true;
                    n_state = ST_COND2;
                end else begin
                    rule_t = cmp_true;
                    rule_done = 1'b1;
                end
            end
            ST_COND2: begin
                cmp_req = r_c2[ri];
                rule_t = (r_link[ri] == LINK_AND) ? (cmp_true && r_t1) : (cmp_true || r_t1);
                rule_done = 1'b1;
                n_state = ST_COND1;
            end
            default: n_state = ST_IDLE;
        endcase
        if (rule_done) begin
            n_idx = r_idx + 1'b1;
            act_k = rule_t ? r_tkind[ri] : r_ekind[ri];
            act_v = rule_t ? r_tval[ri] : r_eval[ri];
            if (act_k == TGT_LEFT || act_k == TGT_BOTH) n_left = act_v;
            if (act_k == TGT_RIGHT || act_k == TGT_BOTH) n_right = act_v;
            flag_sel = act_k - TGT_FLAG;
            flag_we = (act_k >= TGT_FLAG) && ({28'd0, flag_sel} < FLAG_COUNT);
            if (rule_t && act_k >= TGT_LEFT && act_k <= TGT_BOTH) n_pend = r_dur[ri];
        end
        // Load a new transaction: clear the walk state and pick the first step.
        if (accept) begin
            n_idx = '0;
            n_left = '0;
            n_right = '0;
            n_pend = '0;
            n_held = 1'b0;
            n_state = ST_IDLE;
            if (t_op'(i_item.op) == OP_TICK) begin
                if (hold_hit) begin
                    n_left = r_held_l;
                    n_right = r_held_r;
                    n_held = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_COND1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy <= 1'b0;
            r_valid <= 1'b0;
            r_idx <= '0;
            r_flags <= '0;
            r_hold_end <= '0;
            r_held_l <= '0;
            r_held_r <= '0;
            r_hold_run <= 1'b0;
            for (int i = 0; i < RULE_COUNT; i++) begin
                r_active[i] <= 1'b0;
                r_link[i] <= '0;
                r_c1[i] <= '0;
                r_c2[i] <= '0;
                r_tkind[i] <= '0;
                r_tval[i] <= '0;
                r_dur[i] <= '0;
                r_ekind[i] <= '0;
                r_eval[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_t1 <= n_t1;
            r_left <= n_left;
            r_right <= n_right;
            r_pend <= n_pend;
            r_held <= n_held;
            r_valid <= (r_state == ST_DONE);
            if (flag_we) r_flags[flag_sel*16 +: 16] <= act_v;
            if (accept) begin
                r_busy <= 1'b1;
                r_dist <= (i_item.range_timeout || i_item.range_mm >= RANGE_LIMIT) ?
                          RANGE_CLEAN : i_item.range_mm;
                r_line <= i_item.line_sensor;
                r_now <= i_item.now_ms;
                case (t_op'(i_item.op))
                    OP_TICK: begin
                        if (!hold_hit) r_hold_run <= 1'b0;
                    end
                    OP_COND1, OP_COND2, OP_THEN, OP_ELSE: begin
                        if ({28'd0, i_item.rule_index} < RULE_COUNT) begin
                            case (t_op'(i_item.op))
                                OP_COND1: begin
                                    r_active[wr_idx] <= i_item.extra[0];
                                    r_link[wr_idx] <= i_item.extra[2:1];
                                    r_c1[wr_idx] <=
                                        {i_item.kind, i_item.relation, i_item.value};
                                end
                                OP_COND2: r_c2[wr_idx] <=
                                        {i_item.kind, i_item.relation, i_item.value};
                                OP_THEN: begin
                                    r_tkind[wr_idx] <= i_item.kind;
                                    r_tval[wr_idx] <= i_item.value;
                                    r_dur[wr_idx] <= i_item.extra;
                                end
                                default: begin
                                    r_ekind[wr_idx] <= i_item.kind;
                                    r_eval[wr_idx] <= i_item.value;
                                end
                            endcase
                        end
                    end
                    default: ;
                endcase
            end else if (r_state == ST_IDLE) begin
                r_busy <= 1'b0;
            end else if (r_state == ST_DONE) begin
                // Emit the result; lock the speeds if a hold was requested.
                r_busy <= 1'b0;
                if (r_pend != '0) begin
                    r_hold_end <= r_now + {32'd0, r_pend};
                    r_held_l <= r_left;
                    r_held_r <= r_right;
                    r_hold_run <= 1'b1;
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_result.left_speed = r_left;
    assign o_result.right_speed = r_right;
    assign o_result.moving = (r_left != 0) || (r_right != 0);
    assign o_result.held = r_held;

    `ASSERT_IMPLIES(a_valid_not_busy, i_clk, i_rst_n, r_valid, !r_busy)
    `ASSERT_NEXT(a_done_strobe, i_clk, i_rst_n, r_state == ST_DONE, r_valid)
    `ASSERT_IMPLIES(a_walk_busy, i_clk, i_rst_n, r_state != ST_IDLE, r_busy)
    `ASSERT_IMPLIES(a_held_no_pend, i_clk, i_rst_n, r_valid && r_held, r_pend == '0)
endmodule

>>> sim/tb_sensor_rule_action_engine.sv
// Testbench for sensor_rule_action_engine: directed table, then random rule
// programs and ticks, each tick result checked against a local predictor.
// Depends on srae_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_sensor_rule_action_engine;
    import srae_pkg::*;

    localparam int NRULE = 16;
    localparam int NFLAG = 5;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    t_in    i_item = '0;
    logic   o_valid;
    t_out   o_result;

    sensor_rule_action_engine uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_valid(o_valid), .o_result(o_result)
    );

    always #1 i_clk = ~i_clk;

    // Predictor copy of the rule tables and hold timer.
    typedef struct packed {
        logic active; logic [1:0] link;
        logic [3:0] src1; logic [1:0] rel1; logic signed [15:0] thr1;
        logic [3:0] src2; logic [1:0] rel2; logic signed [15:0] thr2;
    } t_cond;
    typedef struct packed {
        logic [3:0] then_kind; logic signed [15:0] then_val; logic [15:0] dur;
        logic [3:0] else_kind; logic signed [15:0] else_val;
    } t_act;

    t_cond              cond_tab [NRULE];
    t_act               act_tab [NRULE];
    logic signed [15:0] flag_val [NFLAG];
    logic [47:0]        hold_end;
    logic signed [15:0] hold_l, hold_r;
    logic               hold_on;

    t_out  speed_q[$];
    int    n_err = 0, n_ticks = 0, n_held = 0, n_sent = 0;
    int    idle_pct = 0;
    logic [47:0] clock_ms = 48'd1000;

    function automatic logic cmp_true(logic [3:0] src, logic [1:0] rel,
                                      logic signed [15:0] thr,
                                      logic signed [16:0] range_v, logic line);
        logic signed [16:0] v;
        if (src == SRC_DIST) v = range_v;
        else if (src == SRC_LINE) v = {16'd0, line};
        else if (src >= SRC_FLAG && src < SRC_FLAG + NFLAG) v = flag_val[src - SRC_FLAG];
        else return 1'b0;
        case (rel)
            REL_LT: return v < thr;
            REL_GT: return v > thr;
            REL_EQ: return v == thr;
            default: return 1'b0;
        endcase
    endfunction

    // Advance the predictor by one accepted transaction.
    task automatic predict_speeds(input t_in it);
        logic signed [16:0] range_v;
        logic signed [15:0] l, r, v;
        logic [15:0] pend;
        logic t;
        logic [3:0] k;
        t_out res;
        case (it.op)
            OP_COND1: begin
                cond_tab[it.rule_index].active = it.extra[0];
                cond_tab[it.rule_index].link = it.extra[2:1];
                cond_tab[it.rule_index].src1 = it.kind;
                cond_tab[it.rule_index].rel1 = it.relation;
                cond_tab[it.rule_index].thr1 = it.value;
            end
            OP_COND2: begin
                cond_tab[it.rule_index].src2 = it.kind;
                cond_tab[it.rule_index].rel2 = it.relation;
                cond_tab[it.rule_index].thr2 = it.value;
            end
            OP_THEN: begin
                act_tab[it.rule_index].then_kind = it.kind;
                act_tab[it.rule_index].then_val = it.value;
                act_tab[it.rule_index].dur = it.extra;
            end
            OP_ELSE: begin
                act_tab[it.rule_index].else_kind = it.kind;
                act_tab[it.rule_index].else_val = it.value;
            end
            OP_TICK: begin
                range_v = (it.range_timeout || it.range_mm >= RANGE_LIMIT)
                          ? 17'sd9999 : $signed({1'b0, it.range_mm});
                l = '0; r = '0; res.held = 1'b0;
                if (hold_on && it.now_ms < hold_end) begin
                    l = hold_l; r = hold_r; res.held = 1'b1;
                end else begin
                    hold_on = 1'b0; pend = '0;
                    for (int i = 0; i < NRULE; i++) begin
                        if (cond_tab[i].active) begin
                            t = cmp_true(cond_tab[i].src1, cond_tab[i].rel1,
                                         cond_tab[i].thr1, range_v, it.line_sensor);
                            if (cond_tab[i].link == LINK_AND)
                                t = t & cmp_true(cond_tab[i].src2, cond_tab[i].rel2,
                                                 cond_tab[i].thr2, range_v, it.line_sensor);
                            else if (cond_tab[i].link == LINK_OR)
                                t = t | cmp_true(cond_tab[i].src2, cond_tab[i].rel2,
                                                 cond_tab[i].thr2, range_v, it.line_sensor);
                            k = t ? act_tab[i].then_kind : act_tab[i].else_kind;
                            v = t ? act_tab[i].then_val : act_tab[i].else_val;
                            if (k == TGT_LEFT) l = v;
                            else if (k == TGT_RIGHT) r = v;
                            else if (k == TGT_BOTH) begin l = v; r = v; end
                            else if (k >= TGT_FLAG && k < TGT_FLAG + NFLAG)
                                flag_val[k - TGT_FLAG] = v;
                            if (t && k >= TGT_LEFT && k <= TGT_BOTH) pend = act_tab[i].dur;
                        end
                    end
                    if (pend != 0) begin
                        hold_end = it.now_ms + pend;
                        hold_l = l; hold_r = r; hold_on = 1'b1;
                    end
                end
                res.left_speed = l; res.right_speed = r;
                res.moving = (l != 0) || (r != 0);
                speed_q.push_back(res);
            end
            default: ;
        endcase
    endtask

    // Check every result strobe against the oldest expected speeds.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (speed_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result %p", o_result);
            end else begin
                t_out e;
                e = speed_q.pop_front();
                n_ticks++;
                if (e.held) n_held++;
                if (o_result !== e) begin
                    n_err++;
                    if (n_err <= 10) $display("mismatch: expected %p actual %p", e, o_result);
                end
            end
        end
    end

    // Drive one transaction, with random idle cycles before it.
    task automatic send(input t_in it);
        @(negedge i_clk);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(negedge i_clk);
        i_item <= it;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_speeds(it);
        n_sent++;
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    function automatic t_in mk(t_op op, logic [3:0] idx, logic [3:0] kind,
                               t_rel rel, logic signed [15:0] val, logic [15:0] ex);
        t_in it;
        it = '0;
        it.op = op; it.rule_index = idx; it.kind = kind;
        it.relation = rel; it.value = val; it.extra = ex;
        return it;
    endfunction

    function automatic t_in mk_tick(logic [15:0] mm, logic tmo, logic line, logic [47:0] ms);
        t_in it;
        it = '0;
        it.op = OP_TICK; it.range_mm = mm; it.range_timeout = tmo;
        it.line_sensor = line; it.now_ms = ms;
        return it;
    endfunction

    function automatic t_in rand_item();
        t_in it;
        it = '0;
        it.op = t_op'($urandom_range(0, 4));
        it.rule_index = 4'($urandom_range(0, 15));
        it.kind = 4'($urandom_range(0, 15));
        it.relation = 2'($urandom_range(0, 3));
        it.value = 16'($urandom);
        it.extra = 16'($urandom);
        it.range_mm = 16'($urandom);
        it.range_timeout = 1'($urandom_range(0, 1));
        it.line_sensor = 1'($urandom_range(0, 1));
        it.now_ms = 48'({$urandom, $urandom});
        return it;
    endfunction

    // Write one well-formed random rule, biased toward useful values.
    task automatic write_rule(input logic [3:0] idx);
        logic [15:0] ex;
        logic signed [15:0] thr;
        thr = ($urandom_range(0, 3) == 0) ? $signed(16'($urandom))
                                           : $signed(16'($urandom_range(0, 10000)));
        ex = {13'd0, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 3) != 0)};
        if ($urandom_range(0, 15) == 0) ex[15:3] = 13'($urandom);
        send(mk(OP_COND1, idx, 4'($urandom_range(0, 8)), t_rel'($urandom_range(0, 3)),
                thr, ex));
        send(mk(OP_COND2, idx, 4'($urandom_range(0, 8)), t_rel'($urandom_range(0, 3)),
                $signed(16'($urandom_range(0, 2))), 16'($urandom)));
        ex = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 300)) : 16'd0;
        if ($urandom_range(0, 30) == 0) ex = 16'hFFFF;
        send(mk(OP_THEN, idx, 4'($urandom_range(0, 9)), REL_LT, 16'($urandom), ex));
        send(mk(OP_ELSE, idx, 4'($urandom_range(0, 9)), REL_LT, 16'($urandom),
                16'($urandom)));
    endtask

    typedef struct {
        t_in  it;
        logic chk;
        t_out res;
    } t_row;

    t_row rows [$];

    initial begin
        t_out zero_res;
        int   pct [4];
        zero_res = '0;
        for (int i = 0; i < NRULE; i++) begin cond_tab[i] = '0; act_tab[i] = '0; end
        for (int i = 0; i < NFLAG; i++) flag_val[i] = '0;
        hold_end = '0; hold_l = '0; hold_r = '0; hold_on = 1'b0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table: empty-table ticks at extremes, then small programs.
        rows.push_back('{mk_tick(16'd0, 1'b0, 1'b0, 48'd0), 1'b1, zero_res});
        rows.push_back('{mk_tick(16'hFFFF, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF), 1'b1, zero_res});
        rows.push_back('{mk(t_op'(3'd5), 4'd0, 4'd0, REL_LT, 16'sd0, 16'hFFFF), 1'b0, zero_res});
        rows.push_back('{mk(t_op'(3'd7), 4'd15, 4'd15, REL_NONE, -16'sd1, 16'hFFFF), 1'b0,
                         zero_res});
        // Rule 0: dist < 8190 then left=-32768 for 50 ms else right=32767.
        rows.push_back('{mk(OP_COND1, 4'd0, SRC_DIST, REL_LT, 16'sd8190, 16'd1), 1'b0, zero_res});
        rows.push_back('{mk(OP_THEN, 4'd0, TGT_LEFT, REL_LT, -16'sd32768, 16'd50), 1'b0,
                         zero_res});
        rows.push_back('{mk(OP_ELSE, 4'd0, TGT_RIGHT, REL_LT, 16'sd32767, 16'd0), 1'b0, zero_res});
        rows.push_back('{mk_tick(16'd8190, 1'b0, 1'b0, 48'd100), 1'b0, zero_res});
        rows.push_back('{mk_tick(16'd8189, 1'b0, 1'b0, 48'd200), 1'b0, zero_res});
        rows.push_back('{mk_tick(16'd0, 1'b1, 1'b0, 48'd249), 1'b0, zero_res});
        rows.push_back('{mk_tick(16'd0, 1'b0, 1'b0, 48'd250), 1'b0, zero_res});
        // Rule 1: line == 1 OR flag0 > 0 sets flag0; rule 2 reads flag0 (AND).
        rows.push_back('{mk(OP_COND1, 4'd1, SRC_LINE, REL_EQ, 16'sd1, 16'd5), 1'b0, zero_res});
        rows.push_back('{mk(OP_COND2, 4'd1, SRC_FLAG, REL_GT, 16'sd0, 16'd0), 1'b0, zero_res});
        rows.push_back('{mk(OP_THEN, 4'd1, TGT_FLAG, REL_LT, 16'sd7, 16'd9), 1'b0, zero_res});
        rows.push_back('{mk(OP_COND1, 4'd2, SRC_FLAG, REL_EQ, 16'sd7, 16'd3), 1'b0, zero_res});
        rows.push_back('{mk(OP_COND2, 4'd2, SRC_LINE, REL_NONE, 16'sd0, 16'd0), 1'b0, zero_res});
        rows.push_back('{mk(OP_ELSE, 4'd2, TGT_BOTH, REL_LT, 16'sd5, 16'd0), 1'b0, zero_res});
        rows.push_back('{mk_tick(16'd9000, 1'b0, 1'b1, 48'd1000), 1'b0, zero_res});
        // Link value three counts only the first condition; unknown target.
        rows.push_back('{mk(OP_COND1, 4'd15, SRC_DIST, REL_GT, -16'sd32768, 16'd7), 1'b0,
                         zero_res});
        rows.push_back('{mk(OP_THEN, 4'd15, 4'd15, REL_LT, 16'sd1, 16'd100), 1'b0, zero_res});
        rows.push_back('{mk_tick(16'd5, 1'b0, 1'b0, 48'd1100), 1'b0, zero_res});
        foreach (rows[i]) begin
            send(rows[i].it);
            if (rows[i].chk) begin
                // The typed row replaces the predictor's entry; a mismatch shows on the port.
                void'(speed_q.pop_back());
                speed_q.push_back(rows[i].res);
            end
        end

        // Random phases with different sender idling.
        pct = '{0, 48, 0, 11};
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = pct[ph];
            // Hold until every expected result has come, then deactivate a random subset of the rules.
            while (speed_q.size() != 0) @(negedge i_clk);
            repeat (40) @(negedge i_clk);
            for (int r = 0; r < NRULE; r++)
                if ($urandom_range(0, 2) == 0)
                    send(mk(OP_COND1, 4'(r), 4'd0, REL_LT, 16'sd0, 16'd0));
            for (int n = 0; n < 160; n++) begin
                int sel;
                sel = $urandom_range(0, 9);
                if (sel < 3) write_rule(4'($urandom_range(0, 15)));
                else if (sel == 3) send(rand_item());
                else begin
                    clock_ms += $urandom_range(0, 3) == 0 ? 48'($urandom_range(0, 400))
                                                          : 48'd100;
                    send(mk_tick($urandom_range(0, 3) == 0 ? 16'($urandom)
                                                           : 16'($urandom_range(0, 9000)),
                                 $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
                                 clock_ms));
                end
            end
        end

        while (speed_q.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        $display("Covered %0d transactions: %0d tick results checked, %0d from a running hold.",
                 n_sent, n_ticks, n_held);
        $display("Mismatches: %0d", n_err);
        if (n_err == 0 && speed_q.size() == 0) begin
            $display("sensor_rule_action_engine test passed");
        end else begin
            $display("sensor_rule_action_engine test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("sensor_rule_action_engine test failed");
        $finish;
    end
endmodule
